// ===== hdl/qbs_pkg.sv =====
// shared constants, types and helpers for the queue of bounded stacks
`timescale 1ns / 1ps

package qbs_pkg;

	localparam int MAX_STACKS = 16;
	localparam int MAX_HEIGHT = 8;

	localparam int PTR_W      = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int CNT_W      = $clog2(MAX_STACKS + 1);
	localparam int FILL_W     = $clog2(MAX_HEIGHT + 1);
	localparam int SLOT_DEPTH = MAX_STACKS * MAX_HEIGHT;
	localparam int ADDR_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

	localparam int DEST_W   = 16;
	localparam int VALUE_W  = 32;
	localparam int ITEM_W   = DEST_W + VALUE_W;
	localparam int LIMIT_W  = 5;
	localparam int HEIGHT_W = 4;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd16;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 4'd8;

	localparam logic REG_LIMIT  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic MODE_STORE = 1'b0;
	localparam logic MODE_SHIP  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [CNT_W-1:0]  limit;
		logic [FILL_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [ITEM_W-1:0] wdata;
	} slot_req_t;

	function automatic logic [CNT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0)
			r = CNT_W'(1);
		else if (32'(v) > 32'(MAX_STACKS))
			r = CNT_W'(MAX_STACKS);
		else
			r = CNT_W'(v);
		return r;
	endfunction

	function automatic logic [FILL_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
		logic [FILL_W-1:0] r;
		if (v == '0)
			r = FILL_W'(1);
		else if (32'(v) > 32'(MAX_HEIGHT))
			r = FILL_W'(MAX_HEIGHT);
		else
			r = FILL_W'(v);
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(MAX_STACKS - 1))
			r = '0;
		else
			r = p + PTR_W'(1);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [PTR_W-1:0] s,
		input logic [FILL_W-1:0] f);
		return ADDR_W'(s) * ADDR_W'(MAX_HEIGHT) + ADDR_W'(f);
	endfunction

endpackage

// ===== hdl/queue_of_bounded_stacks_top.sv =====
// top level of the queue of bounded stacks
`timescale 1ns / 1ps

// A transaction is accepted when start is high and busy is low; the slot ram is
// written or read at that edge, and the result appears for one cycle with done
// high in the next cycle, from the registered read data of the slot ram. busy
// is high in that result cycle, so no transaction is accepted while it is shown.
// The receiver cannot stall results. No clearing pass runs after reset. The user
// must write configuration only while idle; the block does not enforce this.

module queue_of_bounded_stacks_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qbs_pkg::PADDR_W-1:0]   paddr,
	input  logic [qbs_pkg::PDATA_W-1:0]   pwdata,
	output logic [qbs_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [qbs_pkg::DEST_W-1:0]    dest_in,
	input  logic [qbs_pkg::VALUE_W-1:0]   value_in,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [qbs_pkg::DEST_W-1:0]    dest_out,
	output logic [qbs_pkg::VALUE_W-1:0]   value_out
);

	qbs_pkg::cfg_t                 cfg;
	qbs_pkg::slot_req_t            req;
	logic [qbs_pkg::ITEM_W-1:0]    rdata;

	qbs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.mode      (mode),
		.dest_in   (dest_in),
		.value_in  (value_in),
		.busy      (busy),
		.done      (done),
		.status    (status),
		.dest_out  (dest_out),
		.value_out (value_out),
		.req       (req),
		.rdata     (rdata)
	);

	qbs_slot_ram #(
		.DATA_W (qbs_pkg::ITEM_W),
		.DEPTH  (qbs_pkg::SLOT_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (req.we),
		.re    (req.re),
		.addr  (req.addr),
		.wdata (req.wdata),
		.rdata (rdata)
	);

endmodule

// ===== hdl/qbs_slot_ram.sv =====
// single-port synchronous slot ram with registered read data
`timescale 1ns / 1ps

module qbs_slot_ram #(
	parameter int DATA_W = 48,
	parameter int DEPTH = 128,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		if (re)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/qbs_cfg.sv =====
// apb configuration registers with range clamping
`timescale 1ns / 1ps

module qbs_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qbs_pkg::PADDR_W-1:0]  paddr,
	input  logic [qbs_pkg::PDATA_W-1:0]  pwdata,
	output logic [qbs_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output qbs_pkg::cfg_t                cfg
);

	logic [qbs_pkg::LIMIT_W-1:0]  limit_q;
	logic [qbs_pkg::HEIGHT_W-1:0] height_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= qbs_pkg::LIMIT_RESET;
			height_q <= qbs_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				qbs_pkg::REG_LIMIT:  limit_q  <= pwdata[qbs_pkg::LIMIT_W-1:0];
				qbs_pkg::REG_HEIGHT: height_q <= pwdata[qbs_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			qbs_pkg::REG_LIMIT:  prdata = qbs_pkg::PDATA_W'(limit_q);
			qbs_pkg::REG_HEIGHT: prdata = qbs_pkg::PDATA_W'(height_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.limit  = qbs_pkg::clamp_limit(limit_q);
	assign cfg.height = qbs_pkg::clamp_height(height_q);

endmodule

// ===== hdl/qbs_ctrl.sv =====
// ring pointers, fill counts and transaction sequencing around the slot ram
`timescale 1ns / 1ps

module qbs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qbs_pkg::cfg_t                 cfg,
	input  logic                          start,
	input  logic                          mode,
	input  logic [qbs_pkg::DEST_W-1:0]    dest_in,
	input  logic [qbs_pkg::VALUE_W-1:0]   value_in,
	output logic                          busy,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [qbs_pkg::DEST_W-1:0]    dest_out,
	output logic [qbs_pkg::VALUE_W-1:0]   value_out,
	output qbs_pkg::slot_req_t            req,
	input  logic [qbs_pkg::ITEM_W-1:0]    rdata
);

	logic [qbs_pkg::PTR_W-1:0]  oldest_q, newest_q;
	logic [qbs_pkg::CNT_W-1:0]  in_use_q;
	logic [qbs_pkg::FILL_W-1:0] fill_q [qbs_pkg::MAX_STACKS];

	logic                       done_q, ship_ok_q;
	qbs_pkg::status_t           status_q;

	logic                       accept;
	logic                       newest_full, refuse_full, refuse_empty;
	logic [qbs_pkg::PTR_W-1:0]  target;
	logic [qbs_pkg::FILL_W-1:0] base_fill, old_fill, pop_fill;
	logic                       fill_we;
	logic [qbs_pkg::PTR_W-1:0]  fill_idx;
	logic [qbs_pkg::FILL_W-1:0] fill_wval;

	assign accept = start & ~done_q;
	assign busy   = done_q;

	always_comb begin
		newest_full  = (in_use_q == '0) || (fill_q[newest_q] >= cfg.height);
		refuse_full  = newest_full && (in_use_q >= cfg.limit);
		refuse_empty = (in_use_q == '0);
		if (!newest_full)
			target = newest_q;
		else if (in_use_q == '0)
			target = oldest_q;
		else
			target = qbs_pkg::ring_next(newest_q);
		base_fill = newest_full ? '0 : fill_q[newest_q];
		old_fill  = (fill_q[oldest_q] == '0) ? qbs_pkg::FILL_W'(1) : fill_q[oldest_q];
		pop_fill  = old_fill - qbs_pkg::FILL_W'(1);

		req       = '0;
		fill_we   = 1'b0;
		fill_idx  = target;
		fill_wval = base_fill + qbs_pkg::FILL_W'(1);
		if (accept) begin
			unique case (mode)
				qbs_pkg::MODE_STORE: begin
					if (!refuse_full) begin
						req.we    = 1'b1;
						req.addr  = qbs_pkg::slot_addr(target, base_fill);
						req.wdata = {dest_in, value_in};
						fill_we   = 1'b1;
					end
				end
				qbs_pkg::MODE_SHIP: begin
					if (!refuse_empty) begin
						req.re    = 1'b1;
						req.addr  = qbs_pkg::slot_addr(oldest_q, pop_fill);
						fill_we   = 1'b1;
						fill_idx  = oldest_q;
						fill_wval = pop_fill;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we)
			fill_q[fill_idx] <= fill_wval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q  <= '0;
			newest_q  <= '0;
			in_use_q  <= '0;
			done_q    <= 1'b0;
			ship_ok_q <= 1'b0;
			status_q  <= qbs_pkg::ST_DONE;
		end else begin
			done_q    <= accept;
			ship_ok_q <= 1'b0;
			if (accept) begin
				status_q <= qbs_pkg::ST_DONE;
				unique case (mode)
					qbs_pkg::MODE_STORE: begin
						if (refuse_full) begin
							status_q <= qbs_pkg::ST_FULL;
						end else begin
							newest_q <= target;
							if (newest_full)
								in_use_q <= in_use_q + qbs_pkg::CNT_W'(1);
						end
					end
					qbs_pkg::MODE_SHIP: begin
						if (refuse_empty) begin
							status_q <= qbs_pkg::ST_EMPTY;
						end else begin
							ship_ok_q <= 1'b1;
							if (pop_fill == '0) begin
								oldest_q <= qbs_pkg::ring_next(oldest_q);
								in_use_q <= in_use_q - qbs_pkg::CNT_W'(1);
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign dest_out  = ship_ok_q ? rdata[qbs_pkg::ITEM_W-1:qbs_pkg::VALUE_W] : '0;
	assign value_out = ship_ok_q ? rdata[qbs_pkg::VALUE_W-1:0] : '0;

endmodule

// ===== test/queue_of_bounded_stacks_top_tb.sv =====
// self-checking testbench for the queue of bounded stacks: directed and random transactions
`timescale 1ns / 1ps

module queue_of_bounded_stacks_top_tb;
	import qbs_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic               mode;
		logic [DEST_W-1:0]  dest;
		logic [VALUE_W-1:0] value;
	} op_t;

	typedef struct {
		status_t            status;
		logic [DEST_W-1:0]  dest;
		logic [VALUE_W-1:0] value;
	} outcome_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 mode = MODE_STORE;
	logic [DEST_W-1:0]    dest_in = '0;
	logic [VALUE_W-1:0]   value_in = '0;
	logic                 done;
	logic [1:0]           status;
	logic [DEST_W-1:0]    dest_out;
	logic [VALUE_W-1:0]   value_out;

	op_t      pending_ops[$];
	outcome_t pending_results[$];
	op_t      next_op;
	outcome_t want;
	logic     steady = 1'b0;
	int       errors = 0;
	int       stall_cycles = 0;

	// shadow of the ring of stacks
	logic [ITEM_W-1:0]  slot_mem [SLOT_DEPTH];
	int unsigned        fill_cnt [MAX_STACKS];
	int unsigned        head_stack = 0;
	int unsigned        tail_stack = 0;
	int unsigned        live_stacks = 0;
	int unsigned        deepest = 0;
	logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;
	logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;

	int n_stored = 0;
	int n_full = 0;
	int n_shipped = 0;
	int n_empty = 0;
	int n_settings = 1;

	queue_of_bounded_stacks_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.dest_in   (dest_in),
		.value_in  (value_in),
		.done      (done),
		.status    (status),
		.dest_out  (dest_out),
		.value_out (value_out)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic outcome_t stack_ring_step(logic m, logic [DEST_W-1:0] d,
		logic [VALUE_W-1:0] v);
		outcome_t    r;
		int unsigned lim;
		int unsigned hgt;
		int unsigned f;
		logic        newest_full;
		logic [ITEM_W-1:0] item;
		lim = (limit_reg == 0) ? 1 : ((limit_reg > MAX_STACKS) ? MAX_STACKS : limit_reg);
		hgt = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
		r.status = ST_DONE;
		r.dest = '0;
		r.value = '0;
		if (m == MODE_STORE) begin
			newest_full = (live_stacks == 0) || (fill_cnt[tail_stack] >= hgt);
			if (newest_full && live_stacks >= lim) begin
				r.status = ST_FULL;
				n_full++;
			end else begin
				if (newest_full) begin
					if (live_stacks == 0)
						tail_stack = head_stack;
					else
						tail_stack = (tail_stack + 1) % MAX_STACKS;
					fill_cnt[tail_stack] = 0;
					live_stacks++;
					if (live_stacks > deepest)
						deepest = live_stacks;
				end
				slot_mem[tail_stack * MAX_HEIGHT + fill_cnt[tail_stack] % MAX_HEIGHT] = {d, v};
				fill_cnt[tail_stack]++;
				n_stored++;
			end
		end else begin
			if (live_stacks == 0) begin
				r.status = ST_EMPTY;
				n_empty++;
			end else begin
				f = fill_cnt[head_stack];
				if (f == 0)
					f = 1;
				item = slot_mem[head_stack * MAX_HEIGHT + (f - 1) % MAX_HEIGHT];
				r.dest = item[ITEM_W-1:VALUE_W];
				r.value = item[VALUE_W-1:0];
				fill_cnt[head_stack] = f - 1;
				if (fill_cnt[head_stack] == 0) begin
					head_stack = (head_stack + 1) % MAX_STACKS;
					live_stacks--;
				end
				n_shipped++;
			end
		end
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= MODE_STORE;
			dest_in <= '0;
			value_in <= '0;
		end else begin
			if (start && !busy)
				pending_results.push_back(stack_ring_step(mode, dest_in, value_in));
			if (!start || !busy) begin
				if (pending_ops.size() > 0 && (steady || $urandom_range(99) >= 21)) begin
					next_op = pending_ops.pop_front();
					start <= 1'b1;
					mode <= next_op.mode;
					dest_in <= next_op.dest;
					value_in <= next_op.value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no outstanding transaction");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status expected %0d got %0d", want.status, status);
					errors++;
				end
				if (dest_out !== want.dest) begin
					$error("dest_out expected %h got %h", want.dest, dest_out);
					errors++;
				end
				if (value_out !== want.value) begin
					$error("value_out expected %h got %h", want.value, value_out);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("queue_of_bounded_stacks_top: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic push_op(logic m, logic [DEST_W-1:0] d, logic [VALUE_W-1:0] v);
		op_t o;
		o.mode = m;
		o.dest = d;
		o.value = v;
		pending_ops.push_back(o);
	endtask

	task automatic wait_idle();
		while (pending_ops.size() != 0 || pending_results.size() != 0 || start)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(logic [LIMIT_W-1:0] lim, logic [HEIGHT_W-1:0] hgt);
		wait_idle();
		write_reg({REG_LIMIT, 2'b00}, PDATA_W'(lim));
		write_reg({REG_HEIGHT, 2'b00}, PDATA_W'(hgt));
		limit_reg = lim;
		height_reg = hgt;
		n_settings++;
	endtask

	initial begin
		int random_count;
		int phase_idx;
		int n;
		int store_pct;
		logic [LIMIT_W-1:0] lim;
		logic [HEIGHT_W-1:0] hgt;
		random_count = 0;
		phase_idx = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty ship, extremes of the payload, last-in-first-out pops
		push_op(MODE_SHIP, 16'h0000, 32'h0000_0000);
		push_op(MODE_STORE, 16'h0000, 32'h0000_0000);
		push_op(MODE_STORE, 16'hffff, 32'hffff_ffff);
		push_op(MODE_STORE, 16'h5555, 32'haaaa_aaaa);
		push_op(MODE_STORE, 16'haaaa, 32'h5555_5555);
		repeat (4) push_op(MODE_SHIP, 16'hffff, 32'hffff_ffff);
		push_op(MODE_SHIP, 16'h1234, 32'h89ab_cdef);

		// smallest ring: one stack of one item
		set_config(5'd1, 4'd1);
		push_op(MODE_STORE, 16'h0001, 32'h0000_0001);
		push_op(MODE_STORE, 16'h0002, 32'h0000_0002);
		push_op(MODE_SHIP, 16'h0000, 32'h0000_0000);
		push_op(MODE_SHIP, 16'h0000, 32'h0000_0000);

		// zero settings act as one
		set_config(5'd0, 4'd0);
		push_op(MODE_STORE, 16'h00ff, 32'h0000_ffff);
		push_op(MODE_STORE, 16'hff00, 32'hffff_0000);

		// oversized settings act as the maximum
		set_config(5'd31, 4'd15);
		push_op(MODE_STORE, 16'h8000, 32'h8000_0000);
		push_op(MODE_STORE, 16'h7fff, 32'h7fff_ffff);
		push_op(MODE_STORE, 16'hc3c3, 32'h3c3c_3c3c);
		push_op(MODE_SHIP, 16'h0000, 32'h0000_0000);

		// height lowered below the fill of the newest stack
		set_config(5'd2, 4'd2);
		push_op(MODE_STORE, 16'h1111, 32'h1111_1111);
		push_op(MODE_STORE, 16'h2222, 32'h2222_2222);
		push_op(MODE_STORE, 16'h3333, 32'h3333_3333);

		// limit lowered below the stacks in use
		set_config(5'd1, 4'd2);
		push_op(MODE_STORE, 16'h4444, 32'h4444_4444);

		while (random_count < 1350) begin
			phase_idx++;
			steady = (phase_idx == 5 || phase_idx == 6);
			case ($urandom_range(5))
				0: lim = 5'd0;
				1: lim = 5'd1;
				2: lim = 5'd16;
				3: lim = 5'd31;
				default: lim = LIMIT_W'($urandom_range(31));
			endcase
			case ($urandom_range(5))
				0: hgt = 4'd0;
				1: hgt = 4'd1;
				2: hgt = 4'd8;
				3: hgt = 4'd15;
				default: hgt = HEIGHT_W'($urandom_range(15));
			endcase
			set_config(lim, hgt);
			case ($urandom_range(3))
				0: store_pct = 35;
				1: store_pct = 55;
				2: store_pct = 75;
				default: store_pct = 90;
			endcase
			n = $urandom_range(70, 120);
			for (int i = 0; i < n; i++)
				push_op(($urandom_range(99) < store_pct) ? MODE_STORE : MODE_SHIP,
					DEST_W'($urandom), $urandom);
			random_count += n;
		end

		wait_idle();
		repeat (10) @(posedge clk);
		$display("covered %0d settings: %0d stores, %0d refused full, %0d ships, %0d refused empty",
			n_settings, n_stored, n_full, n_shipped, n_empty);
		$display("deepest ring use was %0d stacks", deepest);
		if (errors == 0)
			$display("queue_of_bounded_stacks_top: match");
		else
			$display("queue_of_bounded_stacks_top: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/qbs_pkg.sv
hdl/qbs_slot_ram.sv
hdl/qbs_cfg.sv
hdl/qbs_ctrl.sv
hdl/queue_of_bounded_stacks_top.sv
test/queue_of_bounded_stacks_top_tb.sv
